// ===== hdl/multi_queue_shared_buffer_assert.svh =====
// Assertion macros for the shared-buffer queue block.
`ifndef MULTI_QUEUE_SHARED_BUFFER_ASSERT_SVH
`define MULTI_QUEUE_SHARED_BUFFER_ASSERT_SVH

// Same-cycle implication.
`define MQSB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mqsb assertion failed");

// Next-cycle implication.
`define MQSB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mqsb assertion failed");

// Delayed implication.
`define MQSB_ASSERT_AFTER2(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error("mqsb assertion failed");

`endif

// ===== hdl/mqsb_pkg.sv =====
// Package: sizes, codes and word types of the shared-buffer queue block.
package mqsb_pkg;

   localparam int SLOTS      = 16;
   localparam int QUEUES     = 4;
   localparam int DATA_WIDTH = 32;

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int PTR_W  = $clog2(SLOTS + 1);
   localparam int QIDX_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;

   // a null link is the slot count itself
   localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(SLOTS);

   typedef enum logic {
      CMD_ENQ = 1'b0,
      CMD_DEQ = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      command_type        command;
      logic [1:0]         queue_id;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] data;
      status_type         status;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic launch;
      logic finish;
   } ctl_cmd_type;

endpackage

// ===== hdl/mqsb_ram.sv =====
// Generic RAM: one write port, one read port, registered read data.
module mqsb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/mqsb_ctl.sv =====
// Controller: sequences each operation through launch and finish.
module mqsb_ctl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_strobe,
   output mqsb_pkg::ctl_cmd_type cmd
);

   typedef enum logic {
      S_IDLE,
      S_FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               state_ff      <= S_IDLE;
               rsp_strobe_ff <= 1'b1;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy       = (state_ff == S_FINISH);
   assign rsp_strobe = rsp_strobe_ff;
   assign cmd.launch = start && (state_ff == S_IDLE);
   assign cmd.finish = (state_ff == S_FINISH);

endmodule

// ===== hdl/mqsb_dp.sv =====
// Datapath: slot stores, link valid bits, queue pointers and free list head.
module mqsb_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  mqsb_pkg::ctl_cmd_type cmd,
   input  mqsb_pkg::req_type     req_word,
   output mqsb_pkg::rsp_type     rsp_word
);

   localparam int SW = mqsb_pkg::SLOT_W;
   localparam int PW = mqsb_pkg::PTR_W;
   localparam int QW = mqsb_pkg::QIDX_W;
   localparam int DW = mqsb_pkg::DATA_WIDTH;

   logic [PW-1:0] free_head_ff;
   logic [PW-1:0] head_ff [mqsb_pkg::QUEUES];
   logic [PW-1:0] tail_ff [mqsb_pkg::QUEUES];
   logic [mqsb_pkg::SLOTS-1:0] link_valid_ff;

   mqsb_pkg::command_type cmd_ff;
   logic [QW-1:0]         qidx_ff;
   logic                  err_ff;
   logic [SW-1:0]         slot_ff;
   logic                  rd_valid_ff;
   mqsb_pkg::rsp_type     rsp_ff;

   // launch-cycle decode
   logic          is_enq;
   logic          q_ok;
   logic [QW-1:0] qidx;
   logic [PW-1:0] cur_head;
   logic [PW-1:0] cur_tail;
   logic          head_null;
   logic          free_null;
   logic          err;
   logic [SW-1:0] rd_addr;

   // stores
   logic          data_we;
   logic [DW-1:0] data_q;
   logic          link_we;
   logic [SW-1:0] link_waddr;
   logic [PW-1:0] link_wdata;
   logic [PW-1:0] link_q;
   logic [PW-1:0] link_now;
   logic          head_null_ff;

   always_comb begin
      is_enq    = (req_word.command == mqsb_pkg::CMD_ENQ);
      q_ok      = (32'(req_word.queue_id) < mqsb_pkg::QUEUES);
      qidx      = QW'(req_word.queue_id);
      cur_head  = q_ok ? head_ff[qidx] : mqsb_pkg::NULL_PTR;
      cur_tail  = q_ok ? tail_ff[qidx] : mqsb_pkg::NULL_PTR;
      head_null = (cur_head >= mqsb_pkg::NULL_PTR);
      free_null = (free_head_ff >= mqsb_pkg::NULL_PTR);
      err       = is_enq ? (!q_ok || free_null) : head_null;
      rd_addr   = is_enq ? free_head_ff[SW-1:0] : cur_head[SW-1:0];
   end

   assign data_we = cmd.launch && is_enq && !err;

   mqsb_ram #(
      .WIDTH (DW),
      .DEPTH (mqsb_pkg::SLOTS)
   ) u_data_ram (
      .clock (clock),
      .we    (data_we),
      .waddr (free_head_ff[SW-1:0]),
      .wdata (DW'(req_word.value)),
      .raddr (cur_head[SW-1:0]),
      .rdata (data_q)
   );

   // link port: tail relink at launch, taken slot's link (null or old free head) at finish
   always_comb begin
      link_we    = 1'b0;
      link_waddr = cur_tail[SW-1:0];
      link_wdata = free_head_ff;
      if (cmd.launch) begin
         link_we = is_enq && !err && !head_null;
      end else if (cmd.finish && !err_ff) begin
         link_we    = 1'b1;
         link_waddr = slot_ff;
         link_wdata = (cmd_ff == mqsb_pkg::CMD_ENQ) ? mqsb_pkg::NULL_PTR : free_head_ff;
      end
   end

   mqsb_ram #(
      .WIDTH (PW),
      .DEPTH (mqsb_pkg::SLOTS)
   ) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (link_wdata),
      .raddr (rd_addr),
      .rdata (link_q)
   );

   // an unwritten link (valid bit clear) reads as its initial value: the next slot
   assign link_now     = rd_valid_ff ? link_q : (PW'(slot_ff) + PW'(1));
   assign head_null_ff = (head_ff[qidx_ff] >= mqsb_pkg::NULL_PTR);

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff  <= '0;
         link_valid_ff <= '0;
         for (int i = 0; i < mqsb_pkg::QUEUES; i++) begin
            head_ff[i] <= mqsb_pkg::NULL_PTR;
            tail_ff[i] <= mqsb_pkg::NULL_PTR;
         end
      end else begin
         if (link_we) begin
            link_valid_ff[link_waddr] <= 1'b1;
         end
         if (cmd.finish && !err_ff) begin
            if (cmd_ff == mqsb_pkg::CMD_ENQ) begin
               free_head_ff <= link_now;
               if (head_null_ff) begin
                  head_ff[qidx_ff] <= PW'(slot_ff);
               end
               tail_ff[qidx_ff] <= PW'(slot_ff);
            end else begin
               head_ff[qidx_ff] <= link_now;
               free_head_ff     <= PW'(slot_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.launch) begin
         cmd_ff      <= req_word.command;
         qidx_ff     <= qidx;
         err_ff      <= err;
         slot_ff     <= rd_addr;
         rd_valid_ff <= link_valid_ff[rd_addr];
      end
      if (cmd.finish) begin
         if (cmd_ff == mqsb_pkg::CMD_ENQ) begin
            rsp_ff.data   <= '0;
            rsp_ff.status <= err_ff ? mqsb_pkg::ST_FULL : mqsb_pkg::ST_OK;
         end else if (err_ff) begin
            rsp_ff.data   <= '1;
            rsp_ff.status <= mqsb_pkg::ST_EMPTY;
         end else begin
            rsp_ff.data   <= 32'($signed(data_q));
            rsp_ff.status <= mqsb_pkg::ST_OK;
         end
      end
   end

   assign rsp_word = rsp_ff;

endmodule

// ===== hdl/multi_queue_shared_buffer.sv =====
// Top level: several FIFO queues sharing one slot store with a linked free list.
//
// Usage
//  - Command channel: present req_word (command, queue_id, value) and raise
//    start; the word is taken at a rising edge where start is high and busy
//    is low. Enqueue takes a free slot and links it after the queue's tail;
//    dequeue unlinks the head slot and pushes it onto the free list.
//  - Result channel: one result word per command on rsp_word, shown for a
//    single cycle with rsp_strobe. The receiver cannot stall; it must take
//    the word in that cycle.
//  - Timing: a command spends its launch cycle reading the link and data
//    stores and a finish cycle updating pointers; rsp_strobe is high in the
//    cycle after finish. busy is high only during finish, so a new command
//    can be taken once the last one has finished, a wait set by the
//    registered read of the link store.
//  - Errors: enqueue with no free slot answers status full, data 0; dequeue
//    from an empty queue answers status empty, data all ones. Nothing changes.
//  - Reset (synchronous, active high): all queues empty, every slot free,
//    free list in slot order. Link entries are tracked by valid bits, so no
//    clearing pass is needed; the block accepts commands right after reset.
module multi_queue_shared_buffer (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mqsb_pkg::req_type req_word,
   output logic              rsp_strobe,
   output mqsb_pkg::rsp_type rsp_word
);

   mqsb_pkg::ctl_cmd_type ctl_cmd;

   mqsb_ctl u_ctl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (ctl_cmd)
   );

   mqsb_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (ctl_cmd),
      .req_word (req_word),
      .rsp_word (rsp_word)
   );

endmodule

// ===== hdl/mqsb_checker.sv =====
// Port-level checker for the shared-buffer queue block, bound to the top level.
`include "multi_queue_shared_buffer_assert.svh"

module mqsb_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input mqsb_pkg::rsp_type rsp_word
);

   logic accept;
   logic empty_rsp;

   assign accept    = start && !busy;
   assign empty_rsp = rsp_strobe && (rsp_word.status == mqsb_pkg::ST_EMPTY);

   `MQSB_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, busy)
   `MQSB_ASSERT_AFTER2(a_result_follows, clock, reset, accept, rsp_strobe)
   `MQSB_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_strobe, !rsp_strobe)
   `MQSB_ASSERT_NOW(a_ready_with_result, clock, reset, rsp_strobe, !busy)
   `MQSB_ASSERT_NOW(a_empty_data, clock, reset, empty_rsp, (rsp_word.data == -32'sd1))

endmodule

bind multi_queue_shared_buffer mqsb_checker u_mqsb_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word)
);

// ===== tb/tb_top.sv =====
// Self-checking bench for the shared-buffer multi-queue block: directed and random commands.
module tb_top;
   import mqsb_pkg::*;

   localparam int CLK_HALF       = 6;
   localparam int RESET_CYCLES   = 8;
   // sender gaps stay far below this limit, so a long spell with no word
   // moving either way means the block has hung
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int ITEMS_PER_PHASE = 425;
   localparam int TAIL_CYCLES    = 6;

   // ---------------------------------------------------------------------
   // Scoreboard: a copy of the linked slot store that works out the reply to
   // every command the block takes, and a queue of replies still to come.
   // ---------------------------------------------------------------------
   class shared_queue_model;
      logic [31:0]      slot_val  [SLOTS];
      logic [PTR_W-1:0] slot_next [SLOTS];
      logic [PTR_W-1:0] queue_first [QUEUES];
      logic [PTR_W-1:0] queue_last  [QUEUES];
      logic [PTR_W-1:0] free_top;
      rsp_type          awaited_replies [$];
      int               failures;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            slot_val[i]  = '0;
            slot_next[i] = PTR_W'(i + 1);
         end
         slot_next[SLOTS-1] = NULL_PTR;
         for (int q = 0; q < QUEUES; q++) begin
            queue_first[q] = NULL_PTR;
            queue_last[q]  = NULL_PTR;
         end
         free_top = '0;
         failures = 0;
      endfunction

      function int pending();
         return awaited_replies.size();
      endfunction

      // work out the reply to an accepted command and update the copy
      function void take_command(req_type w);
         rsp_type r;
         int      q;
         int      idx;
         r.data   = '0;
         r.status = ST_OK;
         q        = int'(w.queue_id);
         if (w.command == CMD_ENQ) begin
            if (q >= QUEUES || free_top == NULL_PTR) begin
               r.status = ST_FULL;
            end else begin
               idx      = int'(free_top);
               free_top = slot_next[idx];
               if (queue_first[q] == NULL_PTR) begin
                  queue_first[q] = PTR_W'(idx);
               end else begin
                  slot_next[int'(queue_last[q])] = PTR_W'(idx);
               end
               queue_last[q]  = PTR_W'(idx);
               slot_val[idx]  = w.value;
               slot_next[idx] = NULL_PTR;
            end
         end else begin
            if (q >= QUEUES || queue_first[q] == NULL_PTR) begin
               r.status = ST_EMPTY;
               r.data   = '1;
            end else begin
               // tail goes stale when the queue empties; only the head matters
               idx            = int'(queue_first[q]);
               queue_first[q] = slot_next[idx];
               slot_next[idx] = free_top;
               free_top       = PTR_W'(idx);
               r.data         = slot_val[idx];
            end
         end
         awaited_replies.push_back(r);
      endfunction

      task report_mismatch(string what, rsp_type want, rsp_type got);
         $display("mismatch (%s): want data %h status %0d, got data %h status %0d",
                  what, want.data, want.status, got.data, got.status);
         failures++;
      endtask

      task check_reply(rsp_type got);
         rsp_type want;
         if (awaited_replies.size() == 0) begin
            want = '0;
            report_mismatch("unexpected word", want, got);
         end else begin
            want = awaited_replies.pop_front();
            if (got.data !== want.data) begin
               report_mismatch("data", want, got);
            end else if (got.status !== want.status) begin
               report_mismatch("status", want, got);
            end
         end
      endtask
   endclass

   // ---------------------------------------------------------------------
   // Block under test
   // ---------------------------------------------------------------------
   logic    clock      = 1'b0;
   logic    reset      = 1'b1;
   logic    start      = 1'b0;
   req_type req_word   = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_word;

   multi_queue_shared_buffer uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   shared_queue_model sb = new();
   int                quiet_cycles = 0;

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Monitor: values read here are the ones from before the edge, since all
   // bench inputs move with nonblocking assignments at the same edge.
   // A reply can show at the same edge as a later command is taken, so checking
   // before noting the command taken at this edge keeps the order right.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      logic moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_strobe) begin
            sb.check_reply(rsp_word);
            moved = 1'b1;
         end
         if (start && !busy) begin
            sb.take_command(req_word);
            moved = 1'b1;
         end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Driving tasks. start is left high on return, so back-to-back words need
   // no lowering; the caller drops it only when it means to idle.
   // ---------------------------------------------------------------------
   task automatic send_command(command_type cmd, int q, logic [31:0] val);
      req_type w;
      w.command  = cmd;
      w.queue_id = 2'(q);
      w.value    = val;
      req_word <= w;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // hold the sender off until every reply is back; the first edge lets the
   // monitor note the last word taken before the count is trusted
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(7))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return $urandom_range(1) ? 32'hffff_ffff : 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Random phase. Enqueue share swings between high and low in runs so the
   // store fills up to full and drains back to empty queues, again and again.
   // The sender sits idle in each cycle with the given chance.
   task automatic random_phase(int idle_pct);
      int enq_pct;
      enq_pct = 50;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(2))
               0:       enq_pct = 80;
               1:       enq_pct = 20;
               default: enq_pct = 50;
            endcase
         end
         while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clock);
         end
         send_command(($urandom_range(99) < enq_pct) ? CMD_ENQ : CMD_DEQ,
                      $urandom_range(QUEUES - 1), pick_value());
      end
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: empty dequeue, extreme values, fill to full, full enqueue,
      // emptying a queue and reusing it after its tail went stale
      send_command(CMD_DEQ, 0, 32'h0);
      send_command(CMD_ENQ, 3, 32'h0000_0000);
      send_command(CMD_ENQ, 0, 32'h8000_0000);
      send_command(CMD_ENQ, 1, 32'h7fff_ffff);
      send_command(CMD_ENQ, 2, 32'hffff_ffff);
      for (int i = 0; i < SLOTS - 4; i++) begin
         send_command(CMD_ENQ, i % 3, $urandom);
      end
      send_command(CMD_ENQ, 2, 32'h1234_5678);
      send_command(CMD_DEQ, 3, 32'hffff_ffff);
      send_command(CMD_DEQ, 3, 32'h0);
      send_command(CMD_ENQ, 3, 32'h5a5a_a5a5);
      send_command(CMD_DEQ, 0, 32'h0);
      send_command(CMD_DEQ, 1, 32'h0);
      send_command(CMD_DEQ, 2, 32'h0);
      wait_drained();

      // idle phases: none, sender mostly idle, none (receiver cannot stall),
      // light sender idling; each ends with the sender held until drained
      random_phase(0);
      wait_drained();
      random_phase(81);
      wait_drained();
      random_phase(0);
      wait_drained();
      random_phase(10);
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
